### hdl/afp_pkg.sv
// shared types and sizing constants for the affine-from-three-points solver
// no dependencies
`timescale 1ns / 1ps

package afp_pkg;

    localparam int unsigned CW       = 32;          // coordinate width, Q16.16
    localparam int unsigned DW       = CW + 1;      // coordinate difference width
    localparam int unsigned PW       = 2 * DW;      // difference product width
    localparam int unsigned XW       = PW + 1;      // determinant / cofactor width
    localparam int unsigned HW       = XW - DW;     // upper slice of a cofactor
    localparam int unsigned SPW      = CW + HW;     // partial product width
    localparam int unsigned FULL_W   = CW + XW;     // coordinate times cofactor
    localparam int unsigned NUM_W    = FULL_W + 2;  // constant-term numerator
    localparam int unsigned FRAC     = 16;
    localparam int unsigned QB       = CW + 1;      // quotient bits before saturation
    localparam int unsigned DIV_STAGES = QB + 3;
    localparam int unsigned DIV_BASE = 6;
    localparam int unsigned NSTG     = DIV_BASE + DIV_STAGES + 1;
    localparam int unsigned SING_STAGE = 3;

    localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] src_x0;
        logic signed [CW-1:0] src_y0;
        logic signed [CW-1:0] src_x1;
        logic signed [CW-1:0] src_y1;
        logic signed [CW-1:0] src_x2;
        logic signed [CW-1:0] src_y2;
        logic signed [CW-1:0] dst_s0;
        logic signed [CW-1:0] dst_t0;
        logic signed [CW-1:0] dst_s1;
        logic signed [CW-1:0] dst_t1;
        logic signed [CW-1:0] dst_s2;
        logic signed [CW-1:0] dst_t2;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] s_from_x;
        logic signed [CW-1:0] s_from_y;
        logic signed [CW-1:0] s_offset;
        logic signed [CW-1:0] t_from_x;
        logic signed [CW-1:0] t_from_y;
        logic signed [CW-1:0] t_offset;
        logic                 singular;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [DW-1:0] dx1;
        logic signed [DW-1:0] dy1;
        logic signed [DW-1:0] dx2;
        logic signed [DW-1:0] dy2;
    } t_geo;

endpackage

### hdl/afp_div.sv
// pipelined restoring divider: signed numerator by signed cofactor,
// truncated toward zero, saturated to Q16.16. depends on afp_pkg
`timescale 1ns / 1ps

module afp_div (
    input  logic                                   i_clk,
    input  logic [afp_pkg::DIV_STAGES-1:0]         i_en,
    input  logic signed [afp_pkg::NUM_W-1:0]       i_num,
    input  logic signed [afp_pkg::XW-1:0]          i_den,
    output logic signed [afp_pkg::CW-1:0]          o_quo
);
    import afp_pkg::*;

    logic [NUM_W-1:0] r_na;
    logic [XW-1:0]    r_da;
    logic             r_ng0;

    logic [NUM_W-1:0] r_rem [0:QB];
    logic [XW-1:0]    r_dv  [0:QB];
    logic [QB-1:0]    r_q   [0:QB];
    logic             r_ng  [0:QB];
    logic             r_ov  [0:QB];

    logic [CW-1:0]    n_quo;
    logic [CW-1:0]    r_quo;

    // magnitudes and result sign
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_na  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_da  <= i_den[XW-1] ? XW'(-i_den) : XW'(i_den);
            r_ng0 <= i_num[NUM_W-1] ^ i_den[XW-1];
        end
    end

    // quotient of QB bits or more saturates anyway
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem[0] <= r_na;
            r_dv[0]  <= r_da;
            r_q[0]   <= '0;
            r_ng[0]  <= r_ng0;
            r_ov[0]  <= (r_na >= {1'b0, r_da, {QB{1'b0}}});
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_it
        localparam int unsigned B = QB - 1 - j;
        logic [NUM_W-1:0] w_sub;
        logic             w_ge;
        assign w_sub = NUM_W'(r_dv[j]) << B;
        assign w_ge  = (r_rem[j] >= w_sub);
        always_ff @(posedge i_clk) begin
            if (i_en[2+j]) begin
                r_rem[j+1]    <= w_ge ? r_rem[j] - w_sub : r_rem[j];
                r_q[j+1]      <= r_q[j] | (QB'(w_ge) << B);
                r_dv[j+1]     <= r_dv[j];
                r_ng[j+1]     <= r_ng[j];
                r_ov[j+1]     <= r_ov[j];
            end
        end
    end

    always_comb begin
        if (r_ng[QB]) begin
            if (r_ov[QB] || (r_q[QB] > QB'(SAT_MIN))) n_quo = SAT_MIN;
            else                                      n_quo = CW'(-r_q[QB]);
        end else begin
            if (r_ov[QB] || (r_q[QB] > QB'(SAT_MAX))) n_quo = SAT_MAX;
            else                                      n_quo = r_q[QB][CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STAGES-1]) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

### hdl/afp_row.sv
// one output row lane: cofactors, constant-term numerator and three dividers
// depends on afp_pkg and afp_div
`timescale 1ns / 1ps

module afp_row (
    input  logic                               i_clk,
    input  logic [afp_pkg::NSTG-2:0]           i_en,
    input  afp_pkg::t_geo                      i_geo,
    input  logic signed [afp_pkg::CW-1:0]      i_r0,
    input  logic signed [afp_pkg::CW-1:0]      i_r1,
    input  logic signed [afp_pkg::CW-1:0]      i_r2,
    input  logic signed [afp_pkg::XW-1:0]      i_det2,
    input  logic signed [afp_pkg::XW-1:0]      i_det5,
    output logic signed [afp_pkg::CW-1:0]      o_from_x,
    output logic signed [afp_pkg::CW-1:0]      o_from_y,
    output logic signed [afp_pkg::CW-1:0]      o_offset
);
    import afp_pkg::*;

    logic signed [CW-1:0]     r_r0_0, r_r0_1, r_r0_2;
    logic signed [DW-1:0]     r_dr1_0, r_dr2_0;
    logic signed [CW-1:0]     r_x0_1, r_y0_1, r_x0_2, r_y0_2;
    logic signed [PW-1:0]     r_pa1_1, r_pa2_1, r_pb1_1, r_pb2_1;
    logic signed [XW-1:0]     r_na_2, r_nb_2, r_na_3, r_nb_3, r_na_4, r_nb_4;
    logic signed [SPW-1:0]    r_rdh_3, r_rdl_3, r_xah_3, r_xal_3, r_ybh_3, r_ybl_3;
    logic signed [FULL_W-1:0] r_rd_4, r_xa_4, r_yb_4;
    logic signed [NUM_W-1:0]  r_nc_5, r_sa_5, r_sb_5;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_r0_0  <= i_r0;
            r_dr1_0 <= DW'(i_r1) - DW'(i_r0);
            r_dr2_0 <= DW'(i_r2) - DW'(i_r0);
        end
        if (i_en[1]) begin
            r_pa1_1 <= r_dr1_0 * i_geo.dy2;
            r_pa2_1 <= r_dr2_0 * i_geo.dy1;
            r_pb1_1 <= i_geo.dx1 * r_dr2_0;
            r_pb2_1 <= i_geo.dx2 * r_dr1_0;
            r_r0_1  <= r_r0_0;
            r_x0_1  <= i_geo.x0;
            r_y0_1  <= i_geo.y0;
        end
        if (i_en[2]) begin
            r_na_2 <= XW'(r_pa1_1) - XW'(r_pa2_1);
            r_nb_2 <= XW'(r_pb1_1) - XW'(r_pb2_1);
            r_r0_2 <= r_r0_1;
            r_x0_2 <= r_x0_1;
            r_y0_2 <= r_y0_1;
        end
        // coordinate times cofactor, split into upper signed and lower unsigned halves
        if (i_en[3]) begin
            r_rdh_3 <= r_r0_2 * $signed(i_det2[XW-1:DW]);
            r_rdl_3 <= r_r0_2 * $signed({1'b0, i_det2[DW-1:0]});
            r_xah_3 <= r_x0_2 * $signed(r_na_2[XW-1:DW]);
            r_xal_3 <= r_x0_2 * $signed({1'b0, r_na_2[DW-1:0]});
            r_ybh_3 <= r_y0_2 * $signed(r_nb_2[XW-1:DW]);
            r_ybl_3 <= r_y0_2 * $signed({1'b0, r_nb_2[DW-1:0]});
            r_na_3  <= r_na_2;
            r_nb_3  <= r_nb_2;
        end
        if (i_en[4]) begin
            r_rd_4 <= {r_rdh_3, {DW{1'b0}}} + FULL_W'(r_rdl_3);
            r_xa_4 <= {r_xah_3, {DW{1'b0}}} + FULL_W'(r_xal_3);
            r_yb_4 <= {r_ybh_3, {DW{1'b0}}} + FULL_W'(r_ybl_3);
            r_na_4 <= r_na_3;
            r_nb_4 <= r_nb_3;
        end
        if (i_en[5]) begin
            r_nc_5 <= NUM_W'(r_rd_4) - NUM_W'(r_xa_4) - NUM_W'(r_yb_4);
            r_sa_5 <= NUM_W'($signed({r_na_4, {FRAC{1'b0}}}));
            r_sb_5 <= NUM_W'($signed({r_nb_4, {FRAC{1'b0}}}));
        end
    end

    afp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (i_en[DIV_BASE +: DIV_STAGES]),
        .i_num (r_sa_5),
        .i_den (i_det5),
        .o_quo (o_from_x)
    );

    afp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (i_en[DIV_BASE +: DIV_STAGES]),
        .i_num (r_sb_5),
        .i_den (i_det5),
        .o_quo (o_from_y)
    );

    afp_div u_div_c (
        .i_clk (i_clk),
        .i_en  (i_en[DIV_BASE +: DIV_STAGES]),
        .i_num (r_nc_5),
        .i_den (i_det5),
        .o_quo (o_offset)
    );

endmodule

### hdl/affine_from_three_points_unit.sv
// top level of the affine-from-three-points solver: shared determinant,
// two row lanes, merge and output register. depends on afp_pkg, afp_row
`timescale 1ns / 1ps

// Solves the 2x3 affine matrix that maps three source points onto three
// target points, all in signed Q16.16, by Cramer's rule with exact wide
// intermediates and truncating, saturating divides. One solve enters per
// clock; each result passes in order through six stages of
// differences, products and cofactors, a 36-stage restoring divider made of
// a sign stage, a range check, 33 stages that retire one quotient bit each
// and a saturation stage, and then the output register. The divider
// depth sets the latency; throughput stays one item per cycle while the
// output is taken. Every stage holds a valid bit and a stalled output only
// blocks the stages behind it that are full, so bubbles close up. When the
// source points are collinear the singular flag rises and all six
// coefficients read zero.

module affine_from_three_points_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  afp_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output afp_pkg::t_out  o_data
);
    import afp_pkg::*;

    // per-stage valid bits and load enables
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    // common geometry and the source determinant
    t_geo                 n_geo, r_geo0;
    logic signed [PW-1:0] r_pd1_1, r_pd2_1;
    logic signed [XW-1:0] r_det2, r_det3, r_det4, r_det5;
    logic                 r_sing [SING_STAGE:NSTG-2];

    logic signed [CW-1:0] w_sx, w_sy, w_so, w_tx, w_ty, w_to;
    t_out                 n_out, r_out;

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        n_geo.x0  = i_data.src_x0;
        n_geo.y0  = i_data.src_y0;
        n_geo.dx1 = DW'(i_data.src_x1) - DW'(i_data.src_x0);
        n_geo.dy1 = DW'(i_data.src_y1) - DW'(i_data.src_y0);
        n_geo.dx2 = DW'(i_data.src_x2) - DW'(i_data.src_x0);
        n_geo.dy2 = DW'(i_data.src_y2) - DW'(i_data.src_y0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_geo0 <= n_geo;
        if (w_en[1]) begin
            r_pd1_1 <= r_geo0.dx1 * r_geo0.dy2;
            r_pd2_1 <= r_geo0.dx2 * r_geo0.dy1;
        end
        if (w_en[2]) r_det2 <= XW'(r_pd1_1) - XW'(r_pd2_1);
        if (w_en[3]) r_det3 <= r_det2;
        if (w_en[4]) r_det4 <= r_det3;
        if (w_en[5]) r_det5 <= r_det4;
        // zero determinant follows the item down to the merge
        if (w_en[SING_STAGE]) r_sing[SING_STAGE] <= (r_det2 == '0);
        for (int k = SING_STAGE + 1; k <= NSTG - 2; k++) begin
            if (w_en[k]) r_sing[k] <= r_sing[k-1];
        end
    end

    // s row lane
    afp_row u_row_s (
        .i_clk    (i_clk),
        .i_en     (w_en[NSTG-2:0]),
        .i_geo    (r_geo0),
        .i_r0     (i_data.dst_s0),
        .i_r1     (i_data.dst_s1),
        .i_r2     (i_data.dst_s2),
        .i_det2   (r_det2),
        .i_det5   (r_det5),
        .o_from_x (w_sx),
        .o_from_y (w_sy),
        .o_offset (w_so)
    );

    // t row lane
    afp_row u_row_t (
        .i_clk    (i_clk),
        .i_en     (w_en[NSTG-2:0]),
        .i_geo    (r_geo0),
        .i_r0     (i_data.dst_t0),
        .i_r1     (i_data.dst_t1),
        .i_r2     (i_data.dst_t2),
        .i_det2   (r_det2),
        .i_det5   (r_det5),
        .o_from_x (w_tx),
        .o_from_y (w_ty),
        .o_offset (w_to)
    );

    // merge: zero the coefficients of a singular solve
    always_comb begin
        n_out.singular = r_sing[NSTG-2];
        if (r_sing[NSTG-2]) begin
            n_out.s_from_x = '0;
            n_out.s_from_y = '0;
            n_out.s_offset = '0;
            n_out.t_from_x = '0;
            n_out.t_from_y = '0;
            n_out.t_offset = '0;
        end else begin
            n_out.s_from_x = w_sx;
            n_out.s_from_y = w_sy;
            n_out.s_offset = w_so;
            n_out.t_from_x = w_tx;
            n_out.t_from_y = w_ty;
            n_out.t_offset = w_to;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) r_out <= n_out;
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_data  = r_out;

endmodule

### hdl/afp_checker.sv
// port-level checks for affine_from_three_points_unit and the bind that attaches them
// depends on afp_pkg
`timescale 1ns / 1ps

module afp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input afp_pkg::t_in   i_data,
    input logic           o_valid,
    input logic           i_ready,
    input afp_pkg::t_out  o_data
);
    import afp_pkg::*;

    // output holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");

    // a singular solve carries all-zero coefficients
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |-> o_data.s_from_x == '0 && o_data.s_from_y == '0 &&
            o_data.s_offset == '0 && o_data.t_from_x == '0 &&
            o_data.t_from_y == '0 && o_data.t_offset == '0)
        else $error("singular result with nonzero coefficients");

    // an empty output stage never blocks input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind affine_from_three_points_unit afp_checker u_afp_checker (.*);
